[hw/rtl/ptbmr_pkg.sv]
// Package for the bitmap / Miller-Rabin prime tester.
// Holds payload structs, FSM state codes, constants. No dependencies.
package ptbmr_pkg;

  localparam int unsigned MapBytesDefault = 4096;
  localparam logic [15:0] MapMinLimit = 16'd17;
  localparam logic [63:0] Thresh4 = 64'd3215031751;
  localparam logic [63:0] Thresh5 = 64'd2152302898747;
  localparam logic [63:0] Thresh6 = 64'd3474749660383;

  localparam logic FuncLoad = 1'b0;
  localparam logic FuncTest = 1'b1;

  localparam logic [0:0] RegMaxMap = 1'b0;

  typedef struct packed {
    logic        func;
    logic [11:0] map_index;
    logic [7:0]  map_byte;
    logic [63:0] number;
  } in_item_t;

  typedef struct packed {
    logic        is_prime;
    logic [63:0] tested_number;
  } out_item_t;

  // modmul unit control
  typedef struct packed {
    logic        go;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] m;
  } mm_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SPLIT,
    ST_BASE,
    ST_EXP_MUL,
    ST_EXP_SQR,
    ST_EXP_NEXT,
    ST_CHECK,
    ST_SQ_LOOP,
    ST_SQ_CHECK,
    ST_DONE
  } state_t;

  function automatic logic [4:0] base_value(input logic [2:0] i);
    logic [4:0] v;
    begin
      case (i)
        3'd0: v = 5'd2;
        3'd1: v = 5'd3;
        3'd2: v = 5'd5;
        3'd3: v = 5'd7;
        3'd4: v = 5'd11;
        3'd5: v = 5'd13;
        default: v = 5'd17;
      endcase
      return v;
    end
  endfunction

endpackage

[hw/rtl/ptbmr_modmul.sv]
// Shared 64-bit modular multiplier, shift and add, one bit of b per cycle.
// Depends on ptbmr_pkg. Needs a < m, b < m.
module ptbmr_modmul (
  input  logic                clk,
  input  logic                rst,
  input  ptbmr_pkg::mm_req_t  req,
  output logic                done,
  output logic [63:0]         result
);

  logic [63:0] a, b, m, r;
  logic [6:0]  cnt;
  logic        active;
  logic [63:0] r_dbl, r_add;
  logic [64:0] sum1, sum2;

  // r = 2r mod m, then + a mod m if bit set
  always_comb begin
    sum1  = {1'b0, r} + {1'b0, r};
    r_dbl = (sum1 >= {1'b0, m}) ? sum1[63:0] - m : sum1[63:0];
    sum2  = {1'b0, r_dbl} + {1'b0, a};
    r_add = (sum2 >= {1'b0, m}) ? sum2[63:0] - m : sum2[63:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= !req.go && active && (cnt == 7'd1);
      if (req.go) begin
        active <= 1'b1;
        cnt    <= 7'd64;
        a      <= req.a;
        b      <= req.b;
        m      <= req.m;
        r      <= '0;
      end else if (active) begin
        r   <= b[63] ? r_add : r_dbl;
        b   <= {b[62:0], 1'b0};
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          active <= 1'b0;
        end
      end
    end
  end

  assign result = r;

  a_reduced: assert property (@(posedge clk) disable iff (rst)
    done |-> r < m) else $error("modmul result not reduced");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done longer than one cycle");
  a_go_when_free: assert property (@(posedge clk) disable iff (rst)
    req.go |-> !active) else $error("request while multiplier busy");

endmodule

[hw/rtl/prime_test_bitmap_miller_rabin.sv]
// Prime tester: bitmap lookup for small odd n, Miller-Rabin above the limit.
// Load: busy stays low. Even n: busy through ST_DONE. Bitmap test: busy through ST_LOOKUP, ST_CHECK, ST_DONE.
// Result strobes in the first cycle busy is low again; the receiver must not stall (there is no ready input).
// Miller-Rabin: per base up to 63 exponent bits, each a multiply and a square or a square alone,
// plus up to 62 squarings, all on the one shared multiplier.
// Reset (rst, sync) sets max_map_value to 17; bitmap is not cleared.
module prime_test_bitmap_miller_rabin #(
  parameter int unsigned MAP_BYTES = ptbmr_pkg::MapBytesDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  ptbmr_pkg::in_item_t  in_item,
  output logic                 out_valid,
  output ptbmr_pkg::out_item_t out_item,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [1:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int IW = 60; // n >> 4

  ptbmr_pkg::state_t state, state_next;

  logic [15:0] max_map_value;
  logic [7:0]  mem [MAP_BYTES];
  logic [7:0]  rd_byte;

  logic [63:0] n, d, e, x, bs, nm1;
  logic [5:0]  s, rcnt;
  logic [2:0]  bidx, count;
  logic        verdict;
  logic        lookup_ok;
  logic [2:0]  bitsel;
  // set in ST_LOOKUP for a bitmap lookup, cleared when the next test is accepted
  logic        lookup_mode;

  ptbmr_pkg::mm_req_t mm_req;
  logic               mm_done;
  logic [63:0]        mm_res;

  logic accept, wr_en;
  assign accept = start && !busy;
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign prdata = (paddr[1:0] == {1'b0, ptbmr_pkg::RegMaxMap}) ? {16'd0, max_map_value} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_map_value <= ptbmr_pkg::MapMinLimit;
    end else if (wr_en && paddr == {1'b0, ptbmr_pkg::RegMaxMap}) begin
      max_map_value <= (pwdata[15:0] < ptbmr_pkg::MapMinLimit) ?
                       ptbmr_pkg::MapMinLimit : pwdata[15:0];
    end
  end

  // bitmap memory
  logic [IW-1:0] load_idx_w;
  assign load_idx_w = {{(IW-12){1'b0}}, in_item.map_index};
  always_ff @(posedge clk) begin
    if (accept && in_item.func == ptbmr_pkg::FuncLoad && load_idx_w < IW'(MAP_BYTES)) begin
      mem[load_idx_w[AW-1:0]] <= in_item.map_byte;
    end
    rd_byte <= mem[n[AW+3:4]];
  end

  ptbmr_modmul u_mm (
    .clk    (clk),
    .rst    (rst),
    .req    (mm_req),
    .done   (mm_done),
    .result (mm_res)
  );

  assign busy   = (state != ptbmr_pkg::ST_IDLE);
  assign nm1    = n - 64'd1;
  assign bitsel = n[3:1];
  assign lookup_ok = (n[63:4] < IW'(MAP_BYTES));

  always_ff @(posedge clk) begin
    if (rst) state <= ptbmr_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    mm_req.go = 1'b0;
    mm_req.a  = x;
    mm_req.b  = bs;
    mm_req.m  = n;
    unique case (state)
      ptbmr_pkg::ST_IDLE: begin
        if (accept && in_item.func == ptbmr_pkg::FuncTest) begin
          if (in_item.number == 64'd2 || !in_item.number[0])
            state_next = ptbmr_pkg::ST_DONE;
          else if (in_item.number > {48'd0, max_map_value})
            state_next = ptbmr_pkg::ST_SPLIT;
          else
            state_next = ptbmr_pkg::ST_LOOKUP;
        end
      end
      ptbmr_pkg::ST_LOOKUP: state_next = ptbmr_pkg::ST_CHECK;
      ptbmr_pkg::ST_SPLIT: if (d[0]) state_next = ptbmr_pkg::ST_BASE;
      ptbmr_pkg::ST_BASE: begin
        if (e[0]) begin
          mm_req.go = 1'b1;
          state_next = ptbmr_pkg::ST_EXP_MUL;
        end else begin
          mm_req.go = 1'b1;
          mm_req.a  = bs;
          state_next = ptbmr_pkg::ST_EXP_SQR;
        end
      end
      ptbmr_pkg::ST_EXP_MUL: if (mm_done) state_next = ptbmr_pkg::ST_EXP_NEXT;
      ptbmr_pkg::ST_EXP_NEXT: begin
        mm_req.go = 1'b1;
        mm_req.a  = bs;
        state_next = ptbmr_pkg::ST_EXP_SQR;
      end
      ptbmr_pkg::ST_EXP_SQR: begin
        if (mm_done) begin
          if (e == 64'd0) state_next = ptbmr_pkg::ST_CHECK;
          else            state_next = ptbmr_pkg::ST_BASE;
        end
      end
      ptbmr_pkg::ST_CHECK: begin
        if (lookup_mode)
          state_next = ptbmr_pkg::ST_DONE;
        else if (x == 64'd1 || x == nm1)
          state_next = (bidx + 3'd1 == count) ? ptbmr_pkg::ST_DONE : ptbmr_pkg::ST_BASE;
        else if (rcnt + 6'd1 >= s)
          state_next = ptbmr_pkg::ST_DONE;
        else begin
          mm_req.go = 1'b1;
          mm_req.b  = x;
          state_next = ptbmr_pkg::ST_SQ_LOOP;
        end
      end
      ptbmr_pkg::ST_SQ_LOOP: if (mm_done) state_next = ptbmr_pkg::ST_SQ_CHECK;
      ptbmr_pkg::ST_SQ_CHECK: begin
        if (x == 64'd1)
          state_next = ptbmr_pkg::ST_DONE;
        else if (x == nm1)
          state_next = (bidx + 3'd1 == count) ? ptbmr_pkg::ST_DONE : ptbmr_pkg::ST_BASE;
        else if (rcnt + 6'd1 >= s)
          state_next = ptbmr_pkg::ST_DONE;
        else begin
          mm_req.go = 1'b1;
          mm_req.b  = x;
          state_next = ptbmr_pkg::ST_SQ_LOOP;
        end
      end
      ptbmr_pkg::ST_DONE: state_next = ptbmr_pkg::ST_IDLE;
      default: state_next = ptbmr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= (state == ptbmr_pkg::ST_DONE);
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ptbmr_pkg::ST_IDLE: begin
        if (accept && in_item.func == ptbmr_pkg::FuncTest) begin
          n           <= in_item.number;
          d           <= in_item.number - 64'd1;
          s           <= '0;
          rcnt        <= '0;
          bidx        <= '0;
          lookup_mode <= 1'b0;
          verdict     <= (in_item.number == 64'd2);
          if (in_item.number < ptbmr_pkg::Thresh4)      count <= 3'd4;
          else if (in_item.number < ptbmr_pkg::Thresh5) count <= 3'd5;
          else if (in_item.number < ptbmr_pkg::Thresh6) count <= 3'd6;
          else                                          count <= 3'd7;
        end
      end
      ptbmr_pkg::ST_LOOKUP: lookup_mode <= 1'b1;
      ptbmr_pkg::ST_SPLIT: begin
        if (!d[0]) begin
          d <= {1'b0, d[63:1]};
          s <= s + 6'd1;
        end else begin
          e  <= d;
          x  <= 64'd1;
          bs <= {59'd0, ptbmr_pkg::base_value(3'd0)};
          verdict <= 1'b1;
        end
      end
      ptbmr_pkg::ST_EXP_MUL: if (mm_done) x <= mm_res;
      ptbmr_pkg::ST_EXP_SQR: begin
        if (mm_done) bs <= mm_res;
      end
      ptbmr_pkg::ST_BASE: begin
        e    <= {1'b0, e[63:1]};
        rcnt <= '0;
      end
      ptbmr_pkg::ST_CHECK: begin
        if (lookup_mode) begin
          verdict <= lookup_ok && rd_byte[3'd7 - bitsel];
        end else if (x == 64'd1 || x == nm1) begin
          if (bidx + 3'd1 != count) begin
            bidx <= bidx + 3'd1;
            e    <= d;
            x    <= 64'd1;
            bs   <= {59'd0, ptbmr_pkg::base_value(bidx + 3'd1)};
          end
        end else if (rcnt + 6'd1 >= s) begin
          verdict <= 1'b0;
        end
      end
      ptbmr_pkg::ST_SQ_LOOP: if (mm_done) begin
        x    <= mm_res;
        rcnt <= rcnt + 6'd1;
      end
      ptbmr_pkg::ST_SQ_CHECK: begin
        if (x == 64'd1) verdict <= 1'b0;
        else if (x == nm1) begin
          if (bidx + 3'd1 != count) begin
            bidx <= bidx + 3'd1;
            e    <= d;
            x    <= 64'd1;
            bs   <= {59'd0, ptbmr_pkg::base_value(bidx + 3'd1)};
          end
        end else if (rcnt + 6'd1 >= s) verdict <= 1'b0;
      end
      ptbmr_pkg::ST_DONE: begin
        out_item.is_prime      <= verdict;
        out_item.tested_number <= n;
      end
      default: ;
    endcase
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !accept) else $error("accepted while busy");
  a_out_after_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $past(state == ptbmr_pkg::ST_DONE)) else $error("stray result");
  a_idle_after_done: assert property (@(posedge clk) disable iff (rst)
    state == ptbmr_pkg::ST_DONE |=> state == ptbmr_pkg::ST_IDLE)
    else $error("done not followed by idle");
  a_bidx_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> bidx < count || state == ptbmr_pkg::ST_IDLE) else $error("base index overrun");

endmodule
